// ----- rtl/core/spq_pkg.sv -----
package spq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int PRIORITY_BITS = 8;

   localparam int VALUE_BITS      = 32;
   localparam int IN_PRIO_BITS    = 8;
   localparam int OUT_COUNT_BITS  = 5;
   localparam int INDEX_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS      = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef struct packed {
      logic [VALUE_BITS-1:0]    value;
      logic [PRIORITY_BITS-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic                  wr_en;
      logic [INDEX_BITS-1:0] wr_addr;
      entry_type             wr_entry;
      logic [INDEX_BITS-1:0] rd_addr;
   } store_cmd_type;

   typedef struct packed {
      logic                      strobe;
      logic [VALUE_BITS-1:0]     front_value;
      logic                      front_valid;
      logic [OUT_COUNT_BITS-1:0] entry_count;
      logic                      underflow;
      logic                      overflow;
   } rsp_type;

endpackage

// ----- rtl/core/spq_store.sv -----
module spq_store (
   input  logic                  clock,
   input  spq_pkg::store_cmd_type cmd,
   output spq_pkg::entry_type    rd_entry
);

   spq_pkg::entry_type slots [spq_pkg::QUEUE_DEPTH];
   spq_pkg::entry_type rd_entry_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slots[cmd.wr_addr] <= cmd.wr_entry;
      end
      rd_entry_ff <= slots[cmd.rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ----- rtl/core/spq_seq.sv -----
module spq_seq (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   opcode,
   input  logic signed [spq_pkg::VALUE_BITS-1:0]  item_value,
   input  logic [spq_pkg::IN_PRIO_BITS-1:0]       item_priority,
   input  spq_pkg::entry_type                     rd_entry,
   output logic                                   busy,
   output spq_pkg::store_cmd_type                 cmd,
   output spq_pkg::rsp_type                       rsp
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_STEP  = 3'd2;
   localparam logic [2:0] S_FRONT = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   localparam logic [spq_pkg::COUNT_BITS-1:0] FULL_COUNT =
      spq_pkg::COUNT_BITS'(spq_pkg::QUEUE_DEPTH);
   localparam logic [spq_pkg::COUNT_BITS-1:0] ONE =
      spq_pkg::COUNT_BITS'(1);

   logic [2:0]                         state_ff, state_in;
   logic [spq_pkg::COUNT_BITS-1:0]     count_ff, count_in;
   logic [spq_pkg::COUNT_BITS-1:0]     idx_ff, idx_in;
   logic                               op_ff, op_in;
   spq_pkg::entry_type                 new_ff, new_in;
   logic                               under_ff, under_in;
   logic                               over_ff, over_in;
   logic [spq_pkg::COUNT_BITS-1:0]     idx_dec;
   logic                               moves_back;

   assign idx_dec = idx_ff - ONE;
   // stored entry yields its slot when its priority is strictly lower
   assign moves_back = rd_entry.prio < new_ff.prio;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      op_in    = op_ff;
      new_in   = new_ff;
      under_in = under_ff;
      over_in  = over_ff;

      cmd.wr_en    = 1'b0;
      cmd.wr_addr  = idx_ff[spq_pkg::INDEX_BITS-1:0];
      cmd.wr_entry = rd_entry;
      cmd.rd_addr  = '0;

      rsp.strobe      = 1'b0;
      rsp.front_valid = (count_ff != '0);
      rsp.front_value = rsp.front_valid ? rd_entry.value : '0;
      rsp.entry_count = spq_pkg::OUT_COUNT_BITS'(count_ff);
      rsp.underflow   = under_ff;
      rsp.overflow    = over_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in          = opcode;
               new_in.value   = item_value;
               new_in.prio    = spq_pkg::PRIORITY_BITS'(item_priority);
               under_in       = 1'b0;
               over_in        = 1'b0;
               if (opcode == spq_pkg::OP_PUSH) begin
                  if (count_ff == FULL_COUNT) begin
                     over_in  = 1'b1;
                     state_in = S_FRONT;
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_READ;
                  end
               end else begin
                  if (count_ff == '0) begin
                     under_in = 1'b1;
                     state_in = S_FRONT;
                  end else begin
                     idx_in   = ONE;
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            if (op_ff == spq_pkg::OP_PUSH) begin
               cmd.rd_addr = idx_dec[spq_pkg::INDEX_BITS-1:0];
               if (idx_ff == '0) begin
                  // reached the front: drop the new entry in slot zero
                  cmd.wr_en    = 1'b1;
                  cmd.wr_entry = new_ff;
                  count_in     = count_ff + ONE;
                  state_in     = S_FRONT;
               end else begin
                  state_in = S_STEP;
               end
            end else begin
               cmd.rd_addr = idx_ff[spq_pkg::INDEX_BITS-1:0];
               if (idx_ff == count_ff) begin
                  count_in = count_ff - ONE;
                  state_in = S_FRONT;
               end else begin
                  state_in = S_STEP;
               end
            end
         end
         S_STEP: begin
            cmd.wr_en = 1'b1;
            if (op_ff == spq_pkg::OP_PUSH) begin
               if (moves_back) begin
                  idx_in   = idx_dec;
                  state_in = S_READ;
               end else begin
                  cmd.wr_entry = new_ff;
                  count_in     = count_ff + ONE;
                  state_in     = S_FRONT;
               end
            end else begin
               cmd.wr_addr = idx_dec[spq_pkg::INDEX_BITS-1:0];
               idx_in      = idx_ff + ONE;
               state_in    = S_READ;
            end
         end
         S_FRONT: begin
            cmd.rd_addr = '0;
            state_in    = S_DONE;
         end
         S_DONE: begin
            rsp.strobe = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff   <= idx_in;
      op_ff    <= op_in;
      new_ff   <= new_in;
      under_ff <= under_in;
      over_ff  <= over_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ----- rtl/core/stable_priority_queue_unit.sv -----
// Channel   Direction  Ports                                        Transfer
// request   in         start, busy, req_opcode, req_item_value,     start && !busy
//                      req_item_priority
// response  out        rsp_valid, rsp_front_value, rsp_front_valid, rsp_valid, one cycle
//                      rsp_entry_count, rsp_underflow, rsp_overflow
//
// One request at a time. A push moves each lower-priority entry back one slot,
// from the back, then writes the new entry; a pop shifts each entry behind the
// front forward one slot. Busy stays high for the whole scan: with a single
// storage read port, every entry moved costs one registered read and one write.
// The response rises at the edge where busy falls and lasts one cycle; the
// receiver cannot stall it. Synchronous active-high reset empties the queue
// at once; slot contents are never cleared and never used before written.
module stable_priority_queue_unit (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   output logic                                          busy,
   input  logic                                          req_opcode,
   input  logic signed [spq_pkg::VALUE_BITS-1:0]         req_item_value,
   input  logic [spq_pkg::IN_PRIO_BITS-1:0]              req_item_priority,
   output logic                                          rsp_valid,
   output logic signed [spq_pkg::VALUE_BITS-1:0]         rsp_front_value,
   output logic                                          rsp_front_valid,
   output logic [spq_pkg::OUT_COUNT_BITS-1:0]            rsp_entry_count,
   output logic                                          rsp_underflow,
   output logic                                          rsp_overflow
);

   spq_pkg::store_cmd_type cmd;
   spq_pkg::entry_type     rd_entry;
   spq_pkg::rsp_type       seq_rsp;
   spq_pkg::rsp_type       rsp_ff;

   // sequencer: insertion scan for push, front shift for pop
   spq_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .opcode        (req_opcode),
      .item_value    (req_item_value),
      .item_priority (req_item_priority),
      .rd_entry      (rd_entry),
      .busy          (busy),
      .cmd           (cmd),
      .rsp           (seq_rsp)
   );

   // slot storage, kept in service order
   spq_store u_store (
      .clock    (clock),
      .cmd      (cmd),
      .rd_entry (rd_entry)
   );

   // hold the result in an output register so the sequencer is free
   // to take the next request while the result is on the ports
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.strobe <= 1'b0;
      end else begin
         rsp_ff.strobe <= seq_rsp.strobe;
      end
      if (seq_rsp.strobe) begin
         rsp_ff.front_value <= seq_rsp.front_value;
         rsp_ff.front_valid <= seq_rsp.front_valid;
         rsp_ff.entry_count <= seq_rsp.entry_count;
         rsp_ff.underflow   <= seq_rsp.underflow;
         rsp_ff.overflow    <= seq_rsp.overflow;
      end
   end

   assign rsp_valid       = rsp_ff.strobe;
   assign rsp_front_value = rsp_ff.front_value;
   assign rsp_front_valid = rsp_ff.front_valid;
   assign rsp_entry_count = rsp_ff.entry_count;
   assign rsp_underflow   = rsp_ff.underflow;
   assign rsp_overflow    = rsp_ff.overflow;

endmodule

// ----- verif/stable_priority_queue_unit_test.sv -----
`timescale 1ns / 1ps

module stable_priority_queue_unit_test;

   // Run sizing. Worst case per transfer: a push moving every entry keeps busy
   // up through its whole scan, then the one-cycle response and the longest
   // sender gap, so the limit below is several times the slowest run.
   localparam int DIRECTED_ITEMS = 24;
   localparam int RANDOM_ITEMS   = 1526;
   localparam int CALM_TAIL      = 150;
   localparam int SETTLE_CYCLES  = 2 * spq_pkg::QUEUE_DEPTH + 16;
   localparam int CYCLE_LIMIT    = 400000;

   typedef struct {
      logic                                  opcode;
      logic signed [spq_pkg::VALUE_BITS-1:0] value;
      logic [spq_pkg::IN_PRIO_BITS-1:0]      prio;
      int                                    gap;
   } queue_request_type;

   typedef struct {
      logic signed [spq_pkg::VALUE_BITS-1:0] front_value;
      logic                                  front_valid;
      logic [spq_pkg::OUT_COUNT_BITS-1:0]    entry_count;
      logic                                  underflow;
      logic                                  overflow;
   } queue_status_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  start = 1'b0;
   logic                                  busy;
   logic                                  req_opcode = spq_pkg::OP_PUSH;
   logic signed [spq_pkg::VALUE_BITS-1:0] req_item_value = '0;
   logic [spq_pkg::IN_PRIO_BITS-1:0]      req_item_priority = '0;
   logic                                  rsp_valid;
   logic signed [spq_pkg::VALUE_BITS-1:0] rsp_front_value;
   logic                                  rsp_front_valid;
   logic [spq_pkg::OUT_COUNT_BITS-1:0]    rsp_entry_count;
   logic                                  rsp_underflow;
   logic                                  rsp_overflow;

   stable_priority_queue_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_front_value   (rsp_front_value),
      .rsp_front_valid   (rsp_front_valid),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_underflow     (rsp_underflow),
      .rsp_overflow      (rsp_overflow)
   );

   always #5 clock = ~clock;

   // Commands waiting to be driven, and queue status reports still owed by
   // the block, oldest first.
   queue_request_type pending[$];
   queue_status_type  status_due[$];

   // Shadow copy of the queue contents, kept in service order.
   logic [spq_pkg::VALUE_BITS-1:0]    held_value [spq_pkg::QUEUE_DEPTH];
   logic [spq_pkg::PRIORITY_BITS-1:0] held_prio  [spq_pkg::QUEUE_DEPTH];
   int                                held_count = 0;

   int  idle_left     = 0;
   bit  idle_enabled  = 1'b1;
   int  mismatches    = 0;
   int  cycle_count   = 0;
   int  push_total    = 0;
   int  pop_total     = 0;
   int  overflow_total  = 0;
   int  underflow_total = 0;
   int  peak_fill     = 0;
   int  reports_seen  = 0;

   // Apply one command to the shadow queue and return the status it reports.
   // A push lands behind every entry of equal or higher priority, which keeps
   // equal priorities in arrival order; a full queue drops it.
   function automatic queue_status_type apply_queue_op(
      input logic                             op,
      input logic [spq_pkg::VALUE_BITS-1:0]   value,
      input logic [spq_pkg::IN_PRIO_BITS-1:0] prio);
      queue_status_type                  st;
      logic [spq_pkg::PRIORITY_BITS-1:0] key;
      int                                slot;
      int                                i;
      key          = prio[spq_pkg::PRIORITY_BITS-1:0];
      st.underflow = 1'b0;
      st.overflow  = 1'b0;
      if (op == spq_pkg::OP_PUSH) begin
         push_total++;
         if (held_count >= spq_pkg::QUEUE_DEPTH) begin
            st.overflow = 1'b1;
            overflow_total++;
         end else begin
            slot = 0;
            while (slot < held_count && held_prio[slot] >= key)
               slot++;
            for (i = held_count; i > slot; i--) begin
               held_value[i] = held_value[i-1];
               held_prio[i]  = held_prio[i-1];
            end
            held_value[slot] = value;
            held_prio[slot]  = key;
            held_count++;
            if (held_count > peak_fill)
               peak_fill = held_count;
         end
      end else begin
         pop_total++;
         if (held_count == 0) begin
            st.underflow = 1'b1;
            underflow_total++;
         end else begin
            for (i = 1; i < held_count; i++) begin
               held_value[i-1] = held_value[i];
               held_prio[i-1]  = held_prio[i];
            end
            held_count--;
         end
      end
      st.front_valid = (held_count > 0);
      st.front_value = (held_count > 0) ? held_value[0] : '0;
      st.entry_count = spq_pkg::OUT_COUNT_BITS'(held_count);
      return st;
   endfunction

   // Queue one command; while idling is on, sometimes hold it back by a burst
   // of idle cycles.
   task automatic queue_up(input logic op, input logic [spq_pkg::VALUE_BITS-1:0] value,
                           input logic [spq_pkg::IN_PRIO_BITS-1:0] prio);
      queue_request_type item;
      item.opcode = op;
      item.value  = value;
      item.prio   = prio;
      item.gap    = (idle_enabled && $urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      pending.push_back(item);
   endtask

   function automatic logic [spq_pkg::VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Driver: on every edge, retire the transfer that just happened, then hold
   // the current command while the block is busy, or advance to the next one
   // (after its idle burst, if it has one). start gets at most one assignment per edge.
   always @(posedge clock) begin
      queue_request_type upcoming;
      if (reset) begin
         start     <= 1'b0;
         idle_left  = 0;
      end else begin
         if (start && !busy)
            status_due.push_back(apply_queue_op(req_opcode, req_item_value,
                                                req_item_priority));
         if (!start || !busy) begin
            if (idle_left == 0 && pending.size() > 0 && pending[0].gap > 0) begin
               idle_left      = pending[0].gap;
               pending[0].gap = 0;
            end
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (pending.size() > 0) begin
               upcoming           = pending.pop_front();
               start             <= 1'b1;
               req_opcode        <= upcoming.opcode;
               req_item_value    <= upcoming.value;
               req_item_priority <= upcoming.prio;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string field,
                              input logic [spq_pkg::VALUE_BITS-1:0] want,
                              input logic [spq_pkg::VALUE_BITS-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   // Monitor: every strobed status is a transfer the receiver must take; match
   // it against the oldest report still owed.
   always @(posedge clock) begin
      queue_status_type want;
      if (!reset && rsp_valid) begin
         reports_seen++;
         if (status_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected status, actual value %h valid %b count %0d uf %b of %b",
                     $time, rsp_front_value, rsp_front_valid, rsp_entry_count,
                     rsp_underflow, rsp_overflow);
         end else begin
            want = status_due.pop_front();
            check_field("front_value", want.front_value, rsp_front_value);
            check_field("front_valid", want.front_valid, rsp_front_valid);
            check_field("entry_count", want.entry_count, rsp_entry_count);
            check_field("underflow",   want.underflow,   rsp_underflow);
            check_field("overflow",    want.overflow,    rsp_overflow);
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports still owed", cycle_count,
                  status_due.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int                                made;
      int                                run_len;
      int                                push_pct;
      int                                prio_style;
      int                                k;
      logic                              op;
      logic [spq_pkg::IN_PRIO_BITS-1:0]  prio;

      // Directed: underflow on an empty queue, then a fill that mixes extreme
      // values and priorities with ties on both the top and bottom priority,
      // a push into the full queue, and a partial drain.
      queue_up(spq_pkg::OP_POP,  32'h1234_5678, 8'hFF);
      queue_up(spq_pkg::OP_PUSH, 32'h7FFF_FFFF, 8'hFF);
      queue_up(spq_pkg::OP_PUSH, 32'h8000_0000, 8'h00);
      queue_up(spq_pkg::OP_PUSH, 32'h0000_0000, 8'h80);
      queue_up(spq_pkg::OP_PUSH, 32'hFFFF_FFFF, 8'h80);
      queue_up(spq_pkg::OP_PUSH, 32'h0000_0005, 8'hFF);
      queue_up(spq_pkg::OP_PUSH, 32'h5555_5555, 8'h01);
      queue_up(spq_pkg::OP_PUSH, 32'hAAAA_AAAA, 8'hFE);
      queue_up(spq_pkg::OP_PUSH, 32'h0000_0001, 8'h00);
      for (k = 0; k < 8; k++)
         queue_up(spq_pkg::OP_PUSH, $urandom(),
                  (k % 3 == 0) ? 8'h00 : (k % 3 == 1) ? 8'h80 : 8'hFF);
      queue_up(spq_pkg::OP_PUSH, 32'hDEAD_0001, 8'hFF);
      for (k = 0; k < 5; k++)
         queue_up(spq_pkg::OP_POP, $urandom(), $urandom_range(0, 255));
      queue_up(spq_pkg::OP_PUSH, 32'h0000_007B, 8'hFF);

      // Random: runs with a fixed push bias so the fill level sweeps between
      // empty and full, each with its own priority spread and idle setting.
      // Drop idling for the tail of the run.
      made = 0;
      while (made < RANDOM_ITEMS) begin
         run_len    = $urandom_range(8, 40);
         prio_style = $urandom_range(0, 2);
         case ($urandom_range(0, 3))
            0:       push_pct = 15;
            1:       push_pct = 50;
            2:       push_pct = 85;
            default: push_pct = 97;
         endcase
         idle_enabled = (made < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
         for (k = 0; k < run_len && made < RANDOM_ITEMS; k++) begin
            op = ($urandom_range(1, 100) <= push_pct) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP;
            case (prio_style)
               0:       prio = $urandom_range(0, 255);
               1:       prio = $urandom_range(0, 3);
               default: begin
                  case ($urandom_range(0, 2))
                     0:       prio = 8'h00;
                     1:       prio = 8'hFF;
                     default: prio = $urandom_range(0, 255);
                  endcase
               end
            endcase
            queue_up(op, pick_value(), prio);
            made++;
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait out every transfer and every owed report, then give the block
      // time to show any stray status.
      while (pending.size() != 0 || start || status_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d transfers (%0d push, %0d pop), %0d reports checked",
               DIRECTED_ITEMS + RANDOM_ITEMS, push_total, pop_total, reports_seen);
      $display("full-queue drops %0d, empty pops %0d, peak fill %0d of %0d",
               overflow_total, underflow_total, peak_fill, spq_pkg::QUEUE_DEPTH);
      if (mismatches == 0 && status_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/spq_pkg.sv
rtl/core/spq_store.sv
rtl/core/spq_seq.sv
rtl/core/stable_priority_queue_unit.sv
verif/stable_priority_queue_unit_test.sv
